FILE: src/abfc_pkg.sv
// Package for the readout buffer format checker.
// Holds the channel item types, word tag codes, word classes and limits.
// No dependencies; every other file of the block refers to it by scoped names.
package abfc_pkg;

  // Default sizing, handed to the top level as parameter defaults.
  localparam int MaxBlocksDefault = 22;
  localparam int MaxEventsDefault = 1023;

  // Saturation limits fixed by the field widths.
  localparam logic [21:0] WORDS_MAX  = 22'h3FFFFF;
  localparam logic [12:0] TALLY_MAX  = 13'h1FFF;
  localparam logic [4:0]  BLOCKS_MAX = 5'h1F;
  localparam logic [15:0] ERRS_MAX   = 16'hFFFF;

  // Depth of the queue between front and back.
  localparam int QueueDepth = 2;

  // Type tags, bits 31..27 of a readout word.
  localparam logic [4:0] TAG_BLOCK_HDR    = 5'h10;
  localparam logic [4:0] TAG_BLOCK_TRL    = 5'h11;
  localparam logic [4:0] TAG_EVENT_HDR    = 5'h12;
  localparam logic [4:0] TAG_TRIG_TIME    = 5'h13;
  localparam logic [4:0] TAG_WINDOW_RAW   = 5'h14;
  localparam logic [4:0] TAG_IGN_15       = 5'h15;
  localparam logic [4:0] TAG_PULSE_RAW    = 5'h16;
  localparam logic [4:0] TAG_IGN_17       = 5'h17;
  localparam logic [4:0] TAG_IGN_18       = 5'h18;
  localparam logic [4:0] TAG_IGN_19       = 5'h19;
  localparam logic [4:0] TAG_IGN_1A       = 5'h1A;
  localparam logic [4:0] TAG_IGN_1D       = 5'h1D;
  localparam logic [4:0] TAG_NOT_VALID    = 5'h1E;
  localparam logic [4:0] TAG_FILLER       = 5'h1F;

  // Word class as decided by the front from the tag alone.
  typedef enum logic [3:0] {
    KIND_BLOCK_HDR,
    KIND_BLOCK_TRL,
    KIND_EVENT_HDR,
    KIND_TRIG_TIME,
    KIND_WINDOW_RAW,
    KIND_PULSE_RAW,
    KIND_NOT_VALID,
    KIND_IGNORED,
    KIND_UNKNOWN
  } word_kind_e;

  typedef struct packed {
    logic [31:0] data_word;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  word_type;
    logic        is_continuation;
    logic [2:0]  errors_added;
    logic [15:0] error_total;
    logic        end_of_buffer;
    logic [4:0]  block_total;
    logic        event_count_mismatch;
    logic        data_not_valid;
  } out_item_t;

  // One classified word waiting in the queue.
  typedef struct packed {
    logic [31:0] word;
    logic        last;
    word_kind_e  kind;
  } queue_entry_t;

  // Tag decode; low tags are unknown unless the back consumes them as continuation.
  function automatic word_kind_e classify(input logic [4:0] tag);
    word_kind_e kind;
    case (tag)
      TAG_BLOCK_HDR:  kind = KIND_BLOCK_HDR;
      TAG_BLOCK_TRL:  kind = KIND_BLOCK_TRL;
      TAG_EVENT_HDR:  kind = KIND_EVENT_HDR;
      TAG_TRIG_TIME:  kind = KIND_TRIG_TIME;
      TAG_WINDOW_RAW: kind = KIND_WINDOW_RAW;
      TAG_PULSE_RAW:  kind = KIND_PULSE_RAW;
      TAG_NOT_VALID:  kind = KIND_NOT_VALID;
      TAG_IGN_15, TAG_IGN_17, TAG_IGN_18, TAG_IGN_19,
      TAG_IGN_1A, TAG_IGN_1D, TAG_FILLER: kind = KIND_IGNORED;
      default:        kind = KIND_UNKNOWN;
    endcase
    return kind;
  endfunction

endpackage

FILE: src/abfc_in_if.sv
// Input channel of the format checker: valid, ready and one readout word.
// Depends on abfc_pkg for the item type.
interface abfc_in_if;
  logic               valid;
  logic               ready;
  abfc_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/abfc_out_if.sv
// Result channel of the format checker: valid, ready and one check result.
// Depends on abfc_pkg for the item type.
interface abfc_out_if;
  logic                valid;
  logic                ready;
  abfc_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/adc_block_format_checker.sv
// Channel    Direction  Handshake      Payload
// in_i       input      valid/ready    data_word[31:0], last_word
// out_o      output     valid/ready    word_type, is_continuation, errors_added,
//                                      error_total, end_of_buffer, block_total,
//                                      event_count_mismatch, data_not_valid
//
// One word per cycle sustained while out_o takes each result; a result is offered from the
// result register, which it reaches after the queue write.
// The two-entry queue and the result register let the input keep flowing while
// a result waits; out_o stalls fill the queue, after which in_i.ready drops.
// Reset clears all checker state; the last word of a buffer also returns it to reset.
// Top level of the readout buffer format checker; depends on abfc_pkg,
// the channel interfaces, abfc_front, abfc_queue and abfc_back.
module adc_block_format_checker #(
  parameter int MaxBlocks = abfc_pkg::MaxBlocksDefault,
  parameter int MaxEvents = abfc_pkg::MaxEventsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  abfc_in_if.sink     in_i,
  abfc_out_if.source  out_o
);

  logic                   push_valid, push_ready;
  logic                   pop_valid, pop_ready;
  abfc_pkg::queue_entry_t push_data, pop_data;

  abfc_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  abfc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_data)
  );

  abfc_back #(
    .MaxBlocks (MaxBlocks),
    .MaxEvents (MaxEvents)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_valid_i (pop_valid),
    .rd_ready_o (pop_ready),
    .rd_data_i  (pop_data),
    .out_o      (out_o)
  );

endmodule

FILE: src/abfc_front.sv
// Front of the format checker: accepts readout words and classifies them by tag.
// Depends on abfc_pkg and abfc_in_if; feeds the queue toward the back.
module abfc_front (
  abfc_in_if.sink                   in_i,
  output logic                      push_valid_o,
  input  logic                      push_ready_i,
  output abfc_pkg::queue_entry_t    push_data_o
);

  // The input is ready whenever the queue has room.
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  // Attach the tag class to the word.
  always_comb begin
    push_data_o.word = in_i.payload.data_word;
    push_data_o.last = in_i.payload.last_word;
    push_data_o.kind = abfc_pkg::classify(in_i.payload.data_word[31:27]);
  end

endmodule

FILE: src/abfc_queue.sv
// Short queue between front and back of the format checker.
// Depends on abfc_pkg for the entry type and depth; allows push and pop in one cycle.
module abfc_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_valid_i,
  output logic                   wr_ready_o,
  input  abfc_pkg::queue_entry_t wr_data_i,
  output logic                   rd_valid_o,
  input  logic                   rd_ready_i,
  output abfc_pkg::queue_entry_t rd_data_o
);

  localparam int Depth = abfc_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  abfc_pkg::queue_entry_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign wr_ready_o = (count_q != CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = entry_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage carries payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: src/abfc_back.sv
// Back of the format checker: record and block state, error counting, result register.
// Depends on abfc_pkg and abfc_out_if; takes classified words from the queue.
module abfc_back #(
  parameter int MaxBlocks = abfc_pkg::MaxBlocksDefault,
  parameter int MaxEvents = abfc_pkg::MaxEventsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_valid_i,
  output logic                   rd_ready_o,
  input  abfc_pkg::queue_entry_t rd_data_i,
  abfc_out_if.source             out_o
);

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_TRIG,
    MODE_WINDOW,
    MODE_PULSE
  } cont_mode_e;

  typedef struct packed {
    cont_mode_e  mode;
    logic [4:0]  slot;
    logic [21:0] words;
    logic [4:0]  blocks;
    logic [9:0]  ev_this;
    logic [9:0]  ev_first;
    logic [11:0] win_width;
    logic [12:0] tally;
    logic [15:0] errors;
    logic        mismatch;
    logic        not_valid;
  } state_t;

  localparam state_t StateReset = '{mode: MODE_NONE, default: '0};
  localparam logic [4:0] MaxBlocksW = 5'(MaxBlocks);
  localparam logic [9:0] MaxEventsW = 10'(MaxEvents);

  state_t              st_q, st_d;
  logic                out_valid_q;
  abfc_pkg::out_item_t out_q, out_d;
  logic                take;
  logic [31:0]         w;

  assign w          = rd_data_i.word;
  assign take       = rd_valid_i && (!out_valid_q || out_o.ready);
  assign rd_ready_o = !out_valid_q || out_o.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Per-word checks on the head of the queue.
  always_comb begin
    state_t      s;
    logic [2:0]  added;
    logic        cont;
    logic [16:0] total;

    s     = st_q;
    added = '0;
    cont  = 1'b0;

    if (s.blocks != '0 && s.words != abfc_pkg::WORDS_MAX) begin
      s.words = s.words + 1'b1;
    end

    if (s.mode != MODE_NONE && !w[31]) begin
      // Continuation word of the open record; window raw counts two samples.
      cont = 1'b1;
      if (s.mode == MODE_WINDOW) begin
        s.tally = (s.tally >= abfc_pkg::TALLY_MAX - 13'd1) ? abfc_pkg::TALLY_MAX
                                                          : s.tally + 13'd2;
      end
    end else begin
      // A header word closes any open record first.
      if (s.mode == MODE_WINDOW && {1'b0, s.win_width} != s.tally) begin
        added = added + 1'b1;
      end
      s.mode = MODE_NONE;
      case (rd_data_i.kind)
        abfc_pkg::KIND_BLOCK_HDR: begin
          if (s.blocks == 5'd1) begin
            s.ev_first = s.ev_this;
          end else if (s.blocks >= 5'd2 && s.ev_this != s.ev_first) begin
            s.mismatch = 1'b1;
            added      = added + 1'b1;
          end
          if (s.blocks != abfc_pkg::BLOCKS_MAX) begin
            s.blocks = s.blocks + 1'b1;
          end
          s.slot    = w[26:22];
          s.words   = 22'd1;
          s.ev_this = '0;
        end
        abfc_pkg::KIND_BLOCK_TRL: begin
          if (s.blocks == '0) begin
            added = added + 1'b1;
          end else begin
            if (w[26:22] != s.slot) begin
              added = added + 1'b1;
            end
            if (w[21:0] != s.words) begin
              added = added + 1'b1;
            end
          end
        end
        abfc_pkg::KIND_EVENT_HDR: begin
          if (s.blocks == '0) begin
            added = added + 1'b1;
          end else if (s.ev_this < MaxEventsW) begin
            s.ev_this = s.ev_this + 1'b1;
          end
        end
        abfc_pkg::KIND_TRIG_TIME: begin
          s.mode = MODE_TRIG;
        end
        abfc_pkg::KIND_WINDOW_RAW: begin
          s.win_width = w[11:0];
          s.tally     = '0;
          s.mode      = MODE_WINDOW;
        end
        abfc_pkg::KIND_PULSE_RAW: begin
          s.mode = MODE_PULSE;
        end
        abfc_pkg::KIND_NOT_VALID: begin
          s.not_valid = 1'b1;
        end
        abfc_pkg::KIND_IGNORED: begin
          s.mode = MODE_NONE;
        end
        default: begin
          added = added + 1'b1;
        end
      endcase
    end

    // End of buffer: close the open record and the current block.
    if (rd_data_i.last) begin
      if (s.mode == MODE_WINDOW && {1'b0, s.win_width} != s.tally) begin
        added = added + 1'b1;
      end
      s.mode = MODE_NONE;
      if (s.blocks >= 5'd2 && s.ev_this != s.ev_first) begin
        s.mismatch = 1'b1;
        added      = added + 1'b1;
      end
    end

    total    = {1'b0, s.errors} + 17'(added);
    s.errors = total[16] ? abfc_pkg::ERRS_MAX : total[15:0];

    out_d.word_type            = w[31:27];
    out_d.is_continuation      = cont;
    out_d.errors_added         = added;
    out_d.error_total          = s.errors;
    out_d.end_of_buffer        = rd_data_i.last;
    out_d.block_total          = (s.blocks > MaxBlocksW) ? MaxBlocksW : s.blocks;
    out_d.event_count_mismatch = s.mismatch;
    out_d.data_not_valid       = s.not_valid;

    st_d = rd_data_i.last ? StateReset : s;
  end

  // Checker state and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        st_q <= st_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

endmodule

FILE: src/abfc_checker.sv
// Port-level checks of the readout buffer format checker.
// Depends on abfc_pkg; bound to adc_block_format_checker at the end of this file.
module abfc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input abfc_pkg::out_item_t out_payload_i
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("stalled result changed or dropped");

  // Reset leaves no result offered.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // At most four errors can be found at one word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_payload_i.errors_added <= 3'd4)
    else $error("too many errors at one word");

  // The running total includes the errors of this word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_payload_i.error_total >= 16'(out_payload_i.errors_added))
    else $error("error total below errors of this word");

  // Only words with bit 31 clear are consumed as continuation words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.is_continuation |-> !out_payload_i.word_type[4])
    else $error("continuation word with bit 31 set");

endmodule

bind adc_block_format_checker abfc_checker u_abfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);
